/* rtl/tnsel_pkg.sv */
// ----------------------------------------------------------------------------
// tnsel_pkg
// Shared widths, codes and types of the top-N class selector.
// ----------------------------------------------------------------------------
package tnsel_pkg;

	localparam int SCORE_W = 16;
	localparam int IDX_W   = 10;
	localparam int RANK_W  = 4;
	localparam int STAT_W  = 2;
	localparam int TC_W    = 5;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CONF  = 1'd1;

	localparam logic [STAT_W-1:0] ST_VALID     = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_MATCH  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_COUNT = 2'd2;

	localparam logic [TC_W-1:0] TOP_COUNT_RST = 5'd1;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [IDX_W-1:0]   idx;
	} entry_t;

	typedef struct packed {
		logic load;
		logic bad;
	} hand_t;

	typedef struct packed {
		logic shift;
		logic pop;
	} buf_ctl_t;

	typedef struct packed {
		logic full;
		logic bad;
	} buf_stat_t;

endpackage

/* rtl/tnsel_front.sv */
// ----------------------------------------------------------------------------
// tnsel_front
// Accepts class scores, keeps the sorted top list by compare and shift and
// hands the closed list of a frame to the frame buffer.
// ----------------------------------------------------------------------------
module tnsel_front #(
	parameter int MAX_TOP     = 16,
	parameter int MAX_CLASSES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic [tnsel_pkg::SCORE_W-1:0]         score,
	input  logic                                  frame_end,
	input  logic [tnsel_pkg::TC_W-1:0]            top_count,
	output tnsel_pkg::hand_t                      hand,
	output logic [MAX_TOP-1:0]                    vld_out,
	output tnsel_pkg::entry_t [MAX_TOP-1:0]       list_out
);
	import tnsel_pkg::*;

	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int CW    = (CNT_W > TC_W) ? CNT_W : TC_W;

	logic [MAX_TOP-1:0]           vld_q;
	entry_t [MAX_TOP-1:0]         list_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [MAX_TOP-1:0]           ge;
	logic [MAX_TOP-1:0]           nxt_vld;
	entry_t [MAX_TOP-1:0]         nxt_list;
	entry_t                       new_ent;
	logic                         ins_en;
	logic [CNT_W-1:0]             cnt_nxt;

	assign ins_en  = cnt_q < CNT_W'(MAX_CLASSES);
	assign cnt_nxt = ins_en ? cnt_q + 1'b1 : cnt_q;
	assign new_ent = '{score: score, idx: IDX_W'(cnt_q)};

	always_comb begin
		for (int j = 0; j < MAX_TOP; j++) begin
			ge[j] = vld_q[j] && (list_q[j].score >= score);
		end
		nxt_vld  = vld_q;
		nxt_list = list_q;
		if (ins_en) begin
			if (!ge[0]) begin
				nxt_vld[0]  = 1'b1;
				nxt_list[0] = new_ent;
			end
			for (int j = 1; j < MAX_TOP; j++) begin
				if (!ge[j]) begin
					if (ge[j-1]) begin
						nxt_vld[j]  = 1'b1;
						nxt_list[j] = new_ent;
					end else begin
						nxt_vld[j]  = vld_q[j-1];
						nxt_list[j] = list_q[j-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				vld_q <= '0;
				cnt_q <= '0;
			end else begin
				vld_q <= nxt_vld;
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			list_q <= nxt_list;
		end
	end

	assign hand.load = accept && frame_end;
	assign hand.bad  = (top_count == '0) || (CW'(top_count) > CW'(cnt_nxt));
	assign vld_out   = nxt_vld;
	assign list_out  = nxt_list;

endmodule

/* rtl/tnsel_frame_buf.sv */
// ----------------------------------------------------------------------------
// tnsel_frame_buf
// One-frame queue between front and back: holds a closed top list and
// shifts it towards the head as the back drains it.
// ----------------------------------------------------------------------------
module tnsel_frame_buf #(
	parameter int MAX_TOP = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tnsel_pkg::hand_t                      hand,
	input  logic [MAX_TOP-1:0]                    vld_in,
	input  tnsel_pkg::entry_t [MAX_TOP-1:0]       list_in,
	input  tnsel_pkg::buf_ctl_t                   ctl,
	output tnsel_pkg::buf_stat_t                  stat,
	output logic                                  head_vld,
	output tnsel_pkg::entry_t                     head,
	output logic                                  next_vld,
	output tnsel_pkg::entry_t                     next
);
	import tnsel_pkg::*;

	localparam int ENT_W = $bits(entry_t);

	logic                 full_q;
	logic                 bad_q;
	logic [MAX_TOP-1:0]   vld_q;
	entry_t [MAX_TOP-1:0] list_q;
	logic [MAX_TOP-1:0]   vld_sh;
	entry_t [MAX_TOP-1:0] list_sh;

	assign vld_sh  = vld_q >> 1;
	assign list_sh = list_q >> ENT_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			bad_q  <= 1'b0;
			vld_q  <= '0;
		end else if (hand.load) begin
			full_q <= 1'b1;
			bad_q  <= hand.bad;
			vld_q  <= vld_in;
		end else if (ctl.pop) begin
			full_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= vld_sh;
		end
	end

	always_ff @(posedge clk) begin
		if (hand.load) begin
			list_q <= list_in;
		end else if (ctl.shift) begin
			list_q <= list_sh;
		end
	end

	assign stat.full = full_q;
	assign stat.bad  = bad_q;
	assign head_vld  = vld_q[0];
	assign head      = list_q[0];
	assign next_vld  = vld_sh[0];
	assign next      = list_sh[0];

endmodule

/* rtl/tnsel_back.sv */
// ----------------------------------------------------------------------------
// tnsel_back
// Drains the frame buffer into the output register one result per cycle while
// not stalled, applying the requested count and the confidence threshold.
// ----------------------------------------------------------------------------
module tnsel_back #(
	parameter int MAX_TOP = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [tnsel_pkg::TC_W-1:0]            top_count,
	input  logic [tnsel_pkg::SCORE_W-1:0]         min_conf,
	input  tnsel_pkg::buf_stat_t                  stat,
	input  logic                                  head_vld,
	input  tnsel_pkg::entry_t                     head,
	input  logic                                  next_vld,
	input  tnsel_pkg::entry_t                     next,
	output tnsel_pkg::buf_ctl_t                   ctl,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [tnsel_pkg::IDX_W-1:0]           class_index,
	output logic [tnsel_pkg::SCORE_W-1:0]         confidence,
	output logic [tnsel_pkg::RANK_W-1:0]          rank,
	output logic [tnsel_pkg::STAT_W-1:0]          status,
	output logic                                  list_end
);
	import tnsel_pkg::*;

	localparam int LIM_W = $clog2(MAX_TOP + 1);
	localparam int CW    = (LIM_W > TC_W) ? LIM_W : TC_W;

	logic [LIM_W-1:0]   r_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   class_index_q;
	logic [SCORE_W-1:0] confidence_q;
	logic [RANK_W-1:0]  rank_q;
	logic [STAT_W-1:0]  status_q;
	logic               list_end_q;
	logic [CW-1:0]      limit;
	logic               advance;
	logic               step;
	logic               q0;
	logic               q1;

	assign limit   = (CW'(top_count) < CW'(MAX_TOP)) ? CW'(top_count) : CW'(MAX_TOP);
	assign advance = !out_valid_q || !result_stall;
	assign step    = advance && stat.full;
	assign q0      = (CW'(r_q) < limit) && head_vld && (head.score >= min_conf);
	assign q1      = (CW'(r_q) + 1'b1 < limit) && next_vld && (next.score >= min_conf);

	assign ctl.shift = step && !stat.bad && q0 && q1;
	assign ctl.pop   = step && !(!stat.bad && q0 && q1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			r_q         <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= step;
			end
			if (ctl.pop) begin
				r_q <= '0;
			end else if (ctl.shift) begin
				r_q <= r_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (stat.bad || !q0) begin
				class_index_q <= '0;
				confidence_q  <= '0;
				rank_q        <= '0;
				status_q      <= stat.bad ? ST_BAD_COUNT : ST_NO_MATCH;
				list_end_q    <= 1'b1;
			end else begin
				class_index_q <= head.idx;
				confidence_q  <= head.score;
				rank_q        <= RANK_W'(r_q);
				status_q      <= ST_VALID;
				list_end_q    <= !q1;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign class_index  = class_index_q;
	assign confidence   = confidence_q;
	assign rank         = rank_q;
	assign status       = status_q;
	assign list_end     = list_end_q;

	a_pop_ends_list: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> out_valid_q && list_end_q)
		else $error("frame drained without a closing result");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_VALID) |-> list_end_q)
		else $error("error result not marked as last");

	a_above_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_VALID) |-> confidence_q >= min_conf)
		else $error("emitted entry below threshold");

	a_no_shift_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.shift && ctl.pop))
		else $error("shift and pop together");

endmodule

/* rtl/top_n_class_select_threshold_top.sv */
// ----------------------------------------------------------------------------
// top_n_class_select_threshold_top
// Top-N class selection with a confidence threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall) carries one class score per
//   transaction; the class index is its position in the frame and frame_end
//   flags the last score. Scores are taken one per cycle into a
//   compare-and-shift top list of MAX_TOP cells.
//   When a frame closes, its list moves into a one-frame buffer and the next
//   frame starts at once. The back end drains the buffer one result per
//   cycle through a registered result channel (result_valid/result_stall):
//   the first result passes the buffer and then the output register after the
//   frame_end transaction, and a frame gives 1 to MAX_TOP results.
//   While the buffer still holds a frame, a new frame_end item is stalled;
//   other items keep flowing at one per cycle.
//   A stalled result holds its register and keeps the buffer from draining,
//   so a frame_end item that meets the still full buffer is stalled.
//   Reset empties the list, the buffer and the output register and sets
//   top_count to 1 and min_confidence to 0. Write the configuration only
//   while no frame is in flight.
// ----------------------------------------------------------------------------
module top_n_class_select_threshold_top #(
	parameter int MAX_TOP     = 16,
	parameter int MAX_CLASSES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [tnsel_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tnsel_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic [tnsel_pkg::SCORE_W-1:0]         score,
	input  logic                                  frame_end,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [tnsel_pkg::IDX_W-1:0]           class_index,
	output logic [tnsel_pkg::SCORE_W-1:0]         confidence,
	output logic [tnsel_pkg::RANK_W-1:0]          rank,
	output logic [tnsel_pkg::STAT_W-1:0]          status,
	output logic                                  list_end
);
	import tnsel_pkg::*;

	logic [TC_W-1:0]      top_count_q;
	logic [SCORE_W-1:0]   min_conf_q;
	logic                 accept;
	hand_t                hand;
	logic [MAX_TOP-1:0]   vld_fr;
	entry_t [MAX_TOP-1:0] list_fr;
	buf_ctl_t             ctl;
	buf_stat_t            stat;
	logic                 head_vld;
	entry_t               head;
	logic                 next_vld;
	entry_t               next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= TOP_COUNT_RST;
			min_conf_q  <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_TOP_COUNT) begin
				top_count_q <= cfg_wdata[TC_W-1:0];
			end else if (cfg_index == REG_MIN_CONF) begin
				min_conf_q <= cfg_wdata[SCORE_W-1:0];
			end
		end
	end

	assign item_stall = stat.full && frame_end;
	assign accept     = item_valid && !item_stall;

	tnsel_front #(
		.MAX_TOP     (MAX_TOP),
		.MAX_CLASSES (MAX_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.score     (score),
		.frame_end (frame_end),
		.top_count (top_count_q),
		.hand      (hand),
		.vld_out   (vld_fr),
		.list_out  (list_fr)
	);

	tnsel_frame_buf #(
		.MAX_TOP (MAX_TOP)
	) u_frame_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.hand     (hand),
		.vld_in   (vld_fr),
		.list_in  (list_fr),
		.ctl      (ctl),
		.stat     (stat),
		.head_vld (head_vld),
		.head     (head),
		.next_vld (next_vld),
		.next     (next)
	);

	tnsel_back #(
		.MAX_TOP (MAX_TOP)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.top_count    (top_count_q),
		.min_conf     (min_conf_q),
		.stat         (stat),
		.head_vld     (head_vld),
		.head         (head),
		.next_vld     (next_vld),
		.next         (next),
		.ctl          (ctl),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.class_index  (class_index),
		.confidence   (confidence),
		.rank         (rank),
		.status       (status),
		.list_end     (list_end)
	);

endmodule

/* tb/tb_top_n_class_select_threshold_top.sv */
// ----------------------------------------------------------------------------
// tb_top_n_class_select_threshold_top
// Self-checking bench for the top-N class selector with confidence threshold.
// ----------------------------------------------------------------------------
// A queue of class-score transactions feeds a clocked driver. The driver keeps
// a shadow top list and works out the selected classes of each frame when the
// frame_end transaction is taken. A clocked monitor compares every result
// transaction field by field with the oldest outstanding selection. Directed
// frames cover ties, threshold edges, zero and oversized counts, and a no-match
// frame. Random frames then run under several register settings, with random
// gaps on both channels and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top_n_class_select_threshold_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tnsel_pkg::*;

	localparam int TOP_DEPTH   = 16;
	localparam int CLASS_LIMIT = 1024;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               last;
	} class_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   class_index;
		logic [SCORE_W-1:0] confidence;
		logic [RANK_W-1:0]  rank;
		logic [STAT_W-1:0]  status;
		logic               list_end;
	} sel_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [SCORE_W-1:0]   score = '0;
	logic                 frame_end = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [IDX_W-1:0]     class_index;
	logic [SCORE_W-1:0]   confidence;
	logic [RANK_W-1:0]    rank;
	logic [STAT_W-1:0]    status;
	logic                 list_end;

	class_item_t pending_items[$];
	sel_result_t expected_sel[$];
	class_item_t staged_item;

	logic [SCORE_W-1:0] top_score [TOP_DEPTH];
	logic [IDX_W-1:0]   top_idx   [TOP_DEPTH];
	logic               top_used  [TOP_DEPTH];
	int                 frame_items = 0;
	logic [TC_W-1:0]    cfg_top_count = TOP_COUNT_RST;
	logic [SCORE_W-1:0] cfg_min_conf = '0;

	int send_gap_max = 0;
	int recv_gap_max = 0;
	int send_wait = 0;
	int recv_wait = 0;
	int hold_request = 0;
	int hold_left = 0;
	int mismatch_count = 0;

	top_n_class_select_threshold_top #(
		.MAX_TOP(TOP_DEPTH),
		.MAX_CLASSES(CLASS_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.score(score),
		.frame_end(frame_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.class_index(class_index),
		.confidence(confidence),
		.rank(rank),
		.status(status),
		.list_end(list_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic clear_top_list();
		for (int i = 0; i < TOP_DEPTH; i++) begin
			top_score[i] = '0;
			top_idx[i] = '0;
			top_used[i] = 1'b0;
		end
		frame_items = 0;
	endtask

	task automatic push_selection(input logic [IDX_W-1:0] idx, input logic [SCORE_W-1:0] conf,
			input int place, input logic [STAT_W-1:0] st, input logic last);
		sel_result_t r;
		r.class_index = idx;
		r.confidence = conf;
		r.rank = place[RANK_W-1:0];
		r.status = st;
		r.list_end = last;
		expected_sel = {expected_sel, r};
	endtask

	task automatic rank_score(input logic [SCORE_W-1:0] s, input logic last);
		int pos;
		int j;
		int limit;
		int hits;
		pos = 0;
		if (frame_items < CLASS_LIMIT) begin
			while (pos < TOP_DEPTH && top_used[pos] && top_score[pos] >= s)
				pos++;
			if (pos < TOP_DEPTH) begin
				for (j = TOP_DEPTH - 1; j > pos; j--) begin
					top_score[j] = top_score[j - 1];
					top_idx[j] = top_idx[j - 1];
					top_used[j] = top_used[j - 1];
				end
				top_score[pos] = s;
				top_idx[pos] = frame_items[IDX_W-1:0];
				top_used[pos] = 1'b1;
			end
			frame_items++;
		end
		if (!last)
			return;
		if (cfg_top_count == 0 || cfg_top_count > frame_items) begin
			push_selection('0, '0, 0, ST_BAD_COUNT, 1'b1);
		end else begin
			limit = (cfg_top_count < TOP_DEPTH) ? cfg_top_count : TOP_DEPTH;
			hits = 0;
			while (hits < limit && top_used[hits] && top_score[hits] >= cfg_min_conf)
				hits++;
			if (hits == 0)
				push_selection('0, '0, 0, ST_NO_MATCH, 1'b1);
			for (j = 0; j < hits; j++)
				push_selection(top_idx[j], top_score[j], j, ST_VALID, j == hits - 1);
		end
		clear_top_list();
	endtask

	task automatic check_result();
		sel_result_t want;
		if (expected_sel.size() == 0) begin
			report_mismatch($sformatf("unexpected result, class_index %0d status %0d",
				class_index, status));
			return;
		end
		want = expected_sel.pop_front();
		if (class_index !== want.class_index)
			report_mismatch($sformatf("class_index %0d, expected %0d", class_index,
				want.class_index));
		if (confidence !== want.confidence)
			report_mismatch($sformatf("confidence %h, expected %h", confidence, want.confidence));
		if (rank !== want.rank)
			report_mismatch($sformatf("rank %0d, expected %0d", rank, want.rank));
		if (status !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
		if (list_end !== want.list_end)
			report_mismatch($sformatf("list_end %b, expected %b", list_end, want.list_end));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			score <= '0;
			frame_end <= 1'b0;
			send_wait = 0;
		end else begin
			if (item_valid && !item_stall) begin
				rank_score(score, frame_end);
				send_wait = $urandom_range(0, send_gap_max);
			end
			if (!item_valid || !item_stall) begin
				if (send_wait > 0) begin
					send_wait--;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					staged_item = pending_items.pop_front();
					item_valid <= 1'b1;
					score <= staged_item.score;
					frame_end <= staged_item.last;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				check_result();
				recv_wait = $urandom_range(0, recv_gap_max);
				if (hold_request > 0) begin
					hold_left = hold_request;
					hold_request = 0;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_TOP_COUNT)
			cfg_top_count = val[TC_W-1:0];
		else if (idx == REG_MIN_CONF)
			cfg_min_conf = val[SCORE_W-1:0];
	endtask

	task automatic push_item(input logic [SCORE_W-1:0] s, input logic last);
		class_item_t it;
		it.score = s;
		it.last = last;
		pending_items = {pending_items, it};
	endtask

	function automatic logic [SCORE_W-1:0] pick_score();
		logic [SCORE_W-1:0] s;
		case ($urandom_range(0, 3))
			0, 1: s = SCORE_W'($urandom_range(0, 16'hFFFF));
			2: begin
				case ($urandom_range(0, 3))
					0: s = '0;
					1: s = '1;
					2: s = cfg_min_conf;
					default: s = cfg_min_conf - 1'b1;
				endcase
			end
			default: s = SCORE_W'(16'h4000 * $urandom_range(1, 3));
		endcase
		return s;
	endfunction

	task automatic queue_frames(input int frames, input int min_len, input int max_len);
		int f;
		int k;
		int len;
		for (f = 0; f < frames; f++) begin
			len = $urandom_range(min_len, max_len);
			for (k = 0; k < len; k++)
				push_item(pick_score(), k == len - 1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_sel.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		clear_top_list();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		send_gap_max = 10;
		recv_gap_max = 10;
		push_item(16'hFFFF, 1'b1);
		push_item(16'h0000, 1'b0);
		push_item(16'h0000, 1'b1);
		wait_drained();

		write_reg(REG_TOP_COUNT, 16'hFFE0);
		push_item(16'h1234, 1'b1);
		wait_drained();

		write_reg(REG_TOP_COUNT, 16'd3);
		write_reg(REG_MIN_CONF, 16'h8000);
		push_item(16'h8000, 1'b0);
		push_item(16'h7FFF, 1'b0);
		push_item(16'hFFFF, 1'b0);
		push_item(16'h8000, 1'b1);
		push_item(16'h7FFF, 1'b0);
		push_item(16'h0001, 1'b1);
		push_item(16'h1000, 1'b0);
		push_item(16'h2000, 1'b0);
		push_item(16'h7FFF, 1'b1);
		push_item(16'hAAAA, 1'b0);
		push_item(16'h5555, 1'b0);
		push_item(16'h8001, 1'b1);
		wait_drained();

		write_reg(REG_TOP_COUNT, 16'd5);
		write_reg(REG_MIN_CONF, 16'h4000);
		queue_frames(4, 1, 10);
		wait_drained();

		send_gap_max = 0;
		recv_gap_max = 0;
		write_reg(REG_TOP_COUNT, 16'd16);
		write_reg(REG_MIN_CONF, 16'h0000);
		queue_frames(1, 16, 20);
		wait_drained();

		send_gap_max = 3;
		recv_gap_max = 10;
		write_reg(REG_TOP_COUNT, 16'd31);
		write_reg(REG_MIN_CONF, 16'hFFFF);
		queue_frames(1, 31, 34);
		wait_drained();

		send_gap_max = 0;
		recv_gap_max = 0;
		write_reg(REG_TOP_COUNT, 16'd2);
		write_reg(REG_MIN_CONF, 16'h0000);
		hold_request = 300;
		queue_frames(6, 1, 4);
		wait_drained();

		repeat (2) begin
			send_gap_max = $urandom_range(0, 1) * 10;
			recv_gap_max = $urandom_range(0, 1) * 10;
			write_reg(REG_TOP_COUNT, CFG_W'($urandom_range(1, 16)));
			write_reg(REG_MIN_CONF, CFG_W'($urandom_range(0, 16'hC000)));
			queue_frames(4, 1, 8);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#3ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
rtl/tnsel_pkg.sv
rtl/tnsel_front.sv
rtl/tnsel_frame_buf.sv
rtl/tnsel_back.sv
rtl/top_n_class_select_threshold_top.sv
tb/tb_top_n_class_select_threshold_top.sv
